[rtl/afd_pkg.sv]
// shared constants, item encodings and queue command layout for the adpcm frame decoder
// no dependencies; imported by afd_front, afd_queue, afd_back and the top level
package afd_pkg;

    localparam int NUM_BOOKS        = 8;
    localparam int VECTOR_LEN       = 8;
    localparam int LANES            = 2 * VECTOR_LEN;
    localparam int LANE_W           = $clog2(LANES);
    localparam int BOOK_SLOTS       = NUM_BOOKS * LANES;
    localparam int BOOK_W           = (NUM_BOOKS > 1) ? $clog2(NUM_BOOKS) : 1;
    localparam int J_W              = $clog2(VECTOR_LEN);
    localparam int GRP_W            = $clog2(VECTOR_LEN / 2);
    localparam int FRAME_DATA_BYTES = 8;
    localparam int POS_W            = 4;
    localparam int SCALE_SHIFT      = 11;
    localparam int PROD_W           = 32;
    localparam int ACC_W            = 36;
    localparam int SMP_MAX          = 32767;
    localparam int SMP_MIN          = -32768;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [15:0] smp_t;

    typedef enum logic [1:0] {
        OP_LOAD_COEF   = 2'd0,
        OP_SET_HISTORY = 2'd1,
        OP_STREAM      = 2'd2,
        OP_UNUSED      = 2'd3
    } op_t;

    typedef enum logic {
        CMD_HISTORY = 1'b0,
        CMD_DATA    = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [GRP_W-1:0] group_pos;
        logic             last;
        smp_t             res_hi;
        smp_t             res_lo;
        smp_t             hist_newer;
        smp_t             hist_older;
    } cmd_head_t;

    typedef struct packed {
        cmd_head_t                head;
        smp_t [VECTOR_LEN-1:0]    coef0;
        smp_t [VECTOR_LEN-1:0]    coef1;
    } cmd_t;

endpackage

[rtl/afd_ram.sv]
// generic single write port ram with registered read
// no dependencies
module afd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/afd_front.sv]
// front end: takes input beats, tracks framing, holds the codebook and builds queue commands
// depends on afd_pkg and afd_ram
module afd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [1:0]                    op,
    input  logic [6:0]                    coef_index,
    input  logic signed [15:0]            coef_value,
    input  logic signed [15:0]            history_newer,
    input  logic signed [15:0]            history_older,
    input  logic                          zero_history,
    input  logic [7:0]                    data_byte,
    output logic                          cmd_valid,
    output afd_pkg::cmd_t                 cmd,
    input  logic                          queue_full,
    output logic [afd_pkg::POS_W-1:0]     frame_pos
);
    import afd_pkg::*;

    function automatic smp_t residual_of(input logic [3:0] nib, input logic [3:0] shamt);
        smp_t ext;
        ext = smp_t'({{12{nib[3]}}, nib});
        return ext << shamt;
    endfunction

    logic              stage_valid_reg;
    cmd_head_t         stage_reg;
    cmd_head_t         stage_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [3:0]        shift_reg;
    logic [3:0]        shift_next;
    logic [BOOK_W-1:0] book_reg;
    logic [BOOK_W-1:0] book_next;
    logic              accept;
    logic              load_stage;
    logic              ram_we;
    logic              ram_re;
    op_t               op_code;
    logic [15:0]       lane_rd [LANES];

    assign item_stall = stage_valid_reg && queue_full;
    assign accept     = item_valid && !item_stall;
    assign cmd_valid  = stage_valid_reg && !queue_full;
    assign frame_pos  = pos_reg;

    always_comb
    begin
        op_code    = op_t'(op);
        pos_next   = pos_reg;
        shift_next = shift_reg;
        book_next  = book_reg;
        stage_next = stage_reg;
        load_stage = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        if (accept)
        begin
            unique case (op_code)
                OP_LOAD_COEF:
                begin
                    ram_we = int'(coef_index) < BOOK_SLOTS;
                end
                OP_SET_HISTORY:
                begin
                    load_stage       = 1'b1;
                    stage_next.kind  = CMD_HISTORY;
                    stage_next.hist_newer = zero_history ? smp_t'(0) : history_newer;
                    stage_next.hist_older = zero_history ? smp_t'(0) : history_older;
                    pos_next         = '0;
                end
                OP_STREAM:
                begin
                    if (pos_reg == '0)
                    begin
                        // header: shift in the high nibble, book in the low nibble
                        shift_next = data_byte[7:4];
                        book_next  = BOOK_W'(32'(data_byte[3:0]) % NUM_BOOKS);
                        pos_next   = POS_W'(1);
                    end
                    else
                    begin
                        load_stage           = 1'b1;
                        ram_re               = 1'b1;
                        stage_next.kind      = CMD_DATA;
                        stage_next.group_pos = GRP_W'(pos_reg - 1'b1);
                        stage_next.last      = pos_reg == POS_W'(FRAME_DATA_BYTES);
                        stage_next.res_hi    = residual_of(data_byte[7:4], shift_reg);
                        stage_next.res_lo    = residual_of(data_byte[3:0], shift_reg);
                        pos_next = (pos_reg == POS_W'(FRAME_DATA_BYTES)) ? '0 : pos_reg + 1'b1;
                    end
                end
                OP_UNUSED:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            pos_reg         <= '0;
            shift_reg       <= '0;
            book_reg        <= '0;
        end
        else
        begin
            if (!item_stall)
            begin
                stage_valid_reg <= load_stage;
            end
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
            book_reg  <= book_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_stage)
        begin
            stage_reg <= stage_next;
        end
    end

    // one ram per coefficient lane so a whole book reads out together
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        afd_ram #(
            .WIDTH(16),
            .DEPTH(NUM_BOOKS)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we && (coef_index[LANE_W-1:0] == LANE_W'(g))),
            .waddr (BOOK_W'(coef_index >> LANE_W)),
            .wdata (coef_value),
            .re    (ram_re),
            .raddr (book_reg),
            .rdata (lane_rd[g])
        );
    end

    always_comb
    begin
        cmd.head = stage_reg;
        for (int i = 0; i < VECTOR_LEN; i++)
        begin
            cmd.coef0[i] = lane_rd[i];
            cmd.coef1[i] = lane_rd[VECTOR_LEN + i];
        end
    end

endmodule

[rtl/afd_queue.sv]
// short command queue between the front end and the predictor back end
// depends on afd_pkg
module afd_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  afd_pkg::cmd_t              push_cmd,
    output logic                       full,
    input  logic                       pop,
    output afd_pkg::cmd_t              pop_cmd,
    output logic                       not_empty,
    output logic [afd_pkg::QCNT_W-1:0] count
);
    import afd_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/afd_back.sv]
// back end: residual products, history products, scaling and saturation, output register
// depends on afd_pkg
module afd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_avail,
    input  afd_pkg::cmd_t      cmd,
    output logic               cmd_take,
    output logic               sample_valid,
    input  logic               sample_stall,
    output logic signed [15:0] first_sample,
    output logic signed [15:0] second_sample,
    output logic               last_of_frame
);
    import afd_pkg::*;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic                    grp_start;
        logic                    last;
        smp_t                    res_a;
        smp_t                    res_b;
        smp_t                    c0_a;
        smp_t                    c1_a;
        smp_t                    c0_b;
        smp_t                    c1_b;
        smp_t                    hist_newer;
        smp_t                    hist_older;
        prod_t [VECTOR_LEN-2:0]  prod_a;
        prod_t [VECTOR_LEN-2:0]  prod_b;
    } s1_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      last;
        acc_t      sum_a;
        acc_t      sum_b;
        prod_t     h0_a;
        prod_t     h1_a;
        prod_t     h0_b;
        prod_t     h1_b;
        smp_t      hist_newer;
        smp_t      hist_older;
    } s2_t;

    function automatic smp_t sat16(input acc_t v);
        acc_t q;
        q = v >>> SCALE_SHIFT;
        if (q > acc_t'(SMP_MAX))
        begin
            return smp_t'(SMP_MAX);
        end
        if (q < acc_t'(SMP_MIN))
        begin
            return smp_t'(SMP_MIN);
        end
        return smp_t'(q);
    endfunction

    logic     r1_valid_reg;
    s1_t      r1_reg;
    s1_t      s1_next;
    logic     r2_valid_reg;
    s2_t      r2_reg;
    s2_t      s2_next;
    logic     sample_valid_reg;
    smp_t     first_sample_reg;
    smp_t     second_sample_reg;
    logic     last_of_frame_reg;
    smp_t     recent_newer_reg;
    smp_t     recent_older_reg;
    smp_t     grp_newer_reg;
    smp_t     grp_older_reg;
    smp_t     res_reg [VECTOR_LEN];
    smp_t     cur_res [VECTOR_LEN];
    logic [J_W-1:0] j_a;
    logic [J_W-1:0] j_b;
    smp_t     hist_newer;
    smp_t     hist_older;
    acc_t     tot_a;
    acc_t     tot_b;
    smp_t     samp_a;
    smp_t     samp_b;
    logic     out_free;
    logic     r2_go;
    logic     r2_free;
    logic     r1_go;
    logic     r1_free;

    assign out_free = !sample_valid_reg || !sample_stall;
    assign r2_go    = r2_valid_reg && ((r2_reg.kind == CMD_HISTORY) || out_free);
    assign r2_free  = !r2_valid_reg || r2_go;
    // a group's first byte needs the samples of the item ahead of it, so it waits for that one
    assign r1_go    = r1_valid_reg && r2_free && !(r1_reg.grp_start && r2_valid_reg);
    assign r1_free  = !r1_valid_reg || r1_go;
    assign cmd_take = cmd_avail && r1_free;

    // stage 1: residual terms of the prefix sum
    always_comb
    begin
        j_a = {cmd.head.group_pos, 1'b0};
        j_b = {cmd.head.group_pos, 1'b1};
        for (int k = 0; k < VECTOR_LEN; k++)
        begin
            if (J_W'(k) == j_a)
            begin
                cur_res[k] = cmd.head.res_hi;
            end
            else if (J_W'(k) == j_b)
            begin
                cur_res[k] = cmd.head.res_lo;
            end
            else
            begin
                cur_res[k] = res_reg[k];
            end
        end
        s1_next.kind       = cmd.head.kind;
        s1_next.grp_start  = (cmd.head.kind == CMD_DATA) && (cmd.head.group_pos == '0);
        s1_next.last       = cmd.head.last;
        s1_next.res_a      = cmd.head.res_hi;
        s1_next.res_b      = cmd.head.res_lo;
        s1_next.c0_a       = cmd.coef0[j_a];
        s1_next.c1_a       = cmd.coef1[j_a];
        s1_next.c0_b       = cmd.coef0[j_b];
        s1_next.c1_b       = cmd.coef1[j_b];
        s1_next.hist_newer = cmd.head.hist_newer;
        s1_next.hist_older = cmd.head.hist_older;
        for (int k = 0; k < VECTOR_LEN - 1; k++)
        begin
            if (J_W'(k) < j_a)
            begin
                s1_next.prod_a[k] = $signed(cur_res[k])
                                  * $signed(cmd.coef1[j_a - J_W'(k) - J_W'(1)]);
            end
            else
            begin
                s1_next.prod_a[k] = '0;
            end
            if (J_W'(k) < j_b)
            begin
                s1_next.prod_b[k] = $signed(cur_res[k])
                                  * $signed(cmd.coef1[j_b - J_W'(k) - J_W'(1)]);
            end
            else
            begin
                s1_next.prod_b[k] = '0;
            end
        end
    end

    // stage 2: residual sums and history products
    always_comb
    begin
        hist_older = r1_reg.grp_start ? recent_older_reg : grp_older_reg;
        hist_newer = r1_reg.grp_start ? recent_newer_reg : grp_newer_reg;
        s2_next.kind       = r1_reg.kind;
        s2_next.last       = r1_reg.last;
        s2_next.hist_newer = r1_reg.hist_newer;
        s2_next.hist_older = r1_reg.hist_older;
        s2_next.sum_a      = acc_t'(r1_reg.res_a) <<< SCALE_SHIFT;
        s2_next.sum_b      = acc_t'(r1_reg.res_b) <<< SCALE_SHIFT;
        for (int k = 0; k < VECTOR_LEN - 1; k++)
        begin
            s2_next.sum_a = s2_next.sum_a + acc_t'(r1_reg.prod_a[k]);
            s2_next.sum_b = s2_next.sum_b + acc_t'(r1_reg.prod_b[k]);
        end
        s2_next.h0_a = $signed(r1_reg.c0_a) * $signed(hist_older);
        s2_next.h1_a = $signed(r1_reg.c1_a) * $signed(hist_newer);
        s2_next.h0_b = $signed(r1_reg.c0_b) * $signed(hist_older);
        s2_next.h1_b = $signed(r1_reg.c1_b) * $signed(hist_newer);
    end

    // stage 3: final add, floor by the coefficient scale, saturate
    always_comb
    begin
        tot_a  = r2_reg.sum_a + acc_t'(r2_reg.h0_a) + acc_t'(r2_reg.h1_a);
        tot_b  = r2_reg.sum_b + acc_t'(r2_reg.h0_b) + acc_t'(r2_reg.h1_b);
        samp_a = sat16(tot_a);
        samp_b = sat16(tot_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg     <= 1'b0;
            r2_valid_reg     <= 1'b0;
            sample_valid_reg <= 1'b0;
            recent_newer_reg <= '0;
            recent_older_reg <= '0;
            grp_newer_reg    <= '0;
            grp_older_reg    <= '0;
        end
        else
        begin
            if (r1_free)
            begin
                r1_valid_reg <= cmd_avail;
            end
            if (r2_free)
            begin
                r2_valid_reg <= r1_go;
            end
            if (out_free)
            begin
                sample_valid_reg <= r2_go && (r2_reg.kind == CMD_DATA);
            end
            if (r1_go && r1_reg.grp_start)
            begin
                grp_newer_reg <= recent_newer_reg;
                grp_older_reg <= recent_older_reg;
            end
            if (r2_go)
            begin
                if (r2_reg.kind == CMD_DATA)
                begin
                    recent_older_reg <= samp_a;
                    recent_newer_reg <= samp_b;
                end
                else
                begin
                    recent_older_reg <= r2_reg.hist_older;
                    recent_newer_reg <= r2_reg.hist_newer;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            r1_reg <= s1_next;
            if (cmd.head.kind == CMD_DATA)
            begin
                res_reg <= cur_res;
            end
        end
        if (r1_go)
        begin
            r2_reg <= s2_next;
        end
        if (r2_go && (r2_reg.kind == CMD_DATA))
        begin
            first_sample_reg  <= samp_a;
            second_sample_reg <= samp_b;
            last_of_frame_reg <= r2_reg.last;
        end
    end

    assign sample_valid  = sample_valid_reg;
    assign first_sample  = first_sample_reg;
    assign second_sample = second_sample_reg;
    assign last_of_frame = last_of_frame_reg;

endmodule

[rtl/adpcm_frame_decoder.sv]
// top level of the order-2 vector adpcm frame decoder
// depends on afd_pkg, afd_front, afd_queue and afd_back
//
// Load the codebook one coefficient per beat (op 0), set or clear the two-sample
// history with op 1, which also restarts framing, then stream compressed bytes with
// op 2: a header byte (shift high nibble, book low nibble) followed by eight data bytes,
// each producing one pair of saturated samples, the eighth flagged last_of_frame.
// Headers, coefficient loads and history beats produce no result. A beat can be taken
// every cycle while the queue has room; the back end sustains one data byte per cycle
// while the output is not stalled, except that the first byte of each four-byte group
// (first and fifth data byte of a frame) waits while the item just ahead of it is still
// in the final add stage, since its prediction is built on the two samples that item
// produces. The back end thus falls behind a continuous stream of nine-beat frames,
// and item_stall rises once the queue has filled. A pair is built from its byte
// through the input stage with the registered codebook read, a four-entry queue and
// three predictor stages; the queue and output register let either side stall alone.
module adpcm_frame_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         op,
    input  logic [6:0]         coef_index,
    input  logic signed [15:0] coef_value,
    input  logic signed [15:0] history_newer,
    input  logic signed [15:0] history_older,
    input  logic               zero_history,
    input  logic [7:0]         data_byte,
    output logic               sample_valid,
    input  logic               sample_stall,
    output logic signed [15:0] first_sample,
    output logic signed [15:0] second_sample,
    output logic               last_of_frame
);
    import afd_pkg::*;

    logic              push;
    cmd_t              push_cmd;
    logic              queue_full;
    logic              take;
    cmd_t              head_cmd;
    logic              queue_avail;
    logic [QCNT_W-1:0] queue_count;
    logic [POS_W-1:0]  frame_pos;

    afd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .op            (op),
        .coef_index    (coef_index),
        .coef_value    (coef_value),
        .history_newer (history_newer),
        .history_older (history_older),
        .zero_history  (zero_history),
        .data_byte     (data_byte),
        .cmd_valid     (push),
        .cmd           (push_cmd),
        .queue_full    (queue_full),
        .frame_pos     (frame_pos)
    );

    afd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (take),
        .pop_cmd   (head_cmd),
        .not_empty (queue_avail),
        .count     (queue_count)
    );

    afd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_avail     (queue_avail),
        .cmd           (head_cmd),
        .cmd_take      (take),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .first_sample  (first_sample),
        .second_sample (second_sample),
        .last_of_frame (last_of_frame)
    );

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_pos <= POS_W'(FRAME_DATA_BYTES))
        else $error("frame position beyond last data byte");

    a_history_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && (op == OP_SET_HISTORY)) |=> (frame_pos == '0))
        else $error("set history did not restart framing");

    a_header_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && (op == OP_STREAM) && (frame_pos == '0))
        |=> (frame_pos == POS_W'(1)))
        else $error("header beat did not move to first data byte");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        queue_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue overfilled");

endmodule
